>>> rtl/mris_pkg.sv
package mris_pkg;

    // Fixed field geometry
    localparam int FIELD_DIGITS = 5;
    localparam int TAG_BITS     = 16;
    localparam int COUNT_BITS   = 3;
    localparam int ADDR_BITS    = 5;
    localparam int DATA_BITS    = 32;

    // Default parameter values
    localparam int DEF_MAX_DIMS   = 5;
    localparam int DEF_INDEX_BITS = 32;
    localparam int DEF_BOUND_BITS = 16;

    // Quotient bits resolved per pipeline stage
    localparam int STEP_BITS = 4;

    // Register indexes
    typedef enum logic [2:0] {
        REG_DIMS    = 3'd0,
        REG_BOUND_0 = 3'd1,
        REG_BOUND_1 = 3'd2,
        REG_BOUND_2 = 3'd3,
        REG_BOUND_3 = 3'd4,
        REG_BOUND_4 = 3'd5
    } reg_index_t;

endpackage

>>> rtl/mris_regs.sv
module mris_regs
    import mris_pkg::*;
#(
    parameter int BOUND_BITS = DEF_BOUND_BITS
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [ADDR_BITS-1:0]                      paddr,
    input  logic [DATA_BITS-1:0]                      pwdata,
    output logic [DATA_BITS-1:0]                      prdata,
    output logic                                      pready,
    output logic [COUNT_BITS-1:0]                     dims_in_use,
    output logic [FIELD_DIGITS-1:0][BOUND_BITS-1:0]   bounds
);

    logic [COUNT_BITS-1:0]                   dims_reg;
    logic [FIELD_DIGITS-1:0][BOUND_BITS-1:0] bound_reg;
    logic [2:0]                              idx;
    logic                                    wr_en;

    assign pready      = 1'b1;
    assign idx         = paddr[4:2];
    assign wr_en       = psel && penable && pwrite;
    assign dims_in_use = dims_reg;
    assign bounds      = bound_reg;

    // Hold register file, write on access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg <= COUNT_BITS'(1);
            for (int i = 0; i < FIELD_DIGITS; i++)
            begin
                bound_reg[i] <= BOUND_BITS'(1);
            end
        end
        else if (wr_en)
        begin
            if (idx == REG_DIMS)
            begin
                dims_reg <= pwdata[COUNT_BITS-1:0];
            end
            else if (idx <= REG_BOUND_4)
            begin
                bound_reg[idx - 3'd1] <= pwdata[BOUND_BITS-1:0];
            end
        end
    end

    // Return register value on read
    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_DIMS:    prdata = DATA_BITS'(dims_reg);
            REG_BOUND_0: prdata = DATA_BITS'(bound_reg[0]);
            REG_BOUND_1: prdata = DATA_BITS'(bound_reg[1]);
            REG_BOUND_2: prdata = DATA_BITS'(bound_reg[2]);
            REG_BOUND_3: prdata = DATA_BITS'(bound_reg[3]);
            REG_BOUND_4: prdata = DATA_BITS'(bound_reg[4]);
            default:     prdata = '0;
        endcase
    end

endmodule

>>> rtl/mris_div_stage.sv
module mris_div_stage
    import mris_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS,
    parameter int BOUND_BITS = DEF_BOUND_BITS,
    parameter int FIRST_STEP = 0
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    input  logic [INDEX_BITS-1:0]                     in_num,
    input  logic [BOUND_BITS-1:0]                     in_rem,
    input  logic [FIELD_DIGITS-1:0][BOUND_BITS-1:0]   in_dig,
    input  logic [TAG_BITS-1:0]                       in_tag,
    input  logic [BOUND_BITS-1:0]                     divisor,
    output logic                                      out_valid,
    output logic [INDEX_BITS-1:0]                     out_num,
    output logic [BOUND_BITS-1:0]                     out_rem,
    output logic [FIELD_DIGITS-1:0][BOUND_BITS-1:0]   out_dig,
    output logic [TAG_BITS-1:0]                       out_tag
);

    logic                  valid_reg;
    logic [INDEX_BITS-1:0] num_reg, num_next;
    logic [BOUND_BITS-1:0] rem_reg, rem_next;
    logic [FIELD_DIGITS-1:0][BOUND_BITS-1:0] dig_reg;
    logic [TAG_BITS-1:0]   tag_reg;
    logic [BOUND_BITS-1:0] div_eff;

    // Zero bound divides as one
    assign div_eff = (divisor == '0) ? BOUND_BITS'(1) : divisor;

    // Restoring steps: consume dividend MSB, shift quotient bit into LSB
    always_comb
    begin
        logic [BOUND_BITS:0] trial;
        num_next = in_num;
        rem_next = in_rem;
        trial    = '0;
        for (int k = 0; k < STEP_BITS; k++)
        begin
            if (FIRST_STEP + k < INDEX_BITS)
            begin
                trial    = {rem_next, num_next[INDEX_BITS-1]};
                num_next = {num_next[INDEX_BITS-2:0], 1'b0};
                if (trial >= {1'b0, div_eff})
                begin
                    trial       = trial - {1'b0, div_eff};
                    num_next[0] = 1'b1;
                end
                rem_next = trial[BOUND_BITS-1:0];
            end
        end
    end

    // Advance valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        dig_reg <= in_dig;
        tag_reg <= in_tag;
    end

    assign out_valid = valid_reg;
    assign out_num   = num_reg;
    assign out_rem   = rem_reg;
    assign out_dig   = dig_reg;
    assign out_tag   = tag_reg;

endmodule

>>> rtl/mixed_radix_index_split.sv
// Mixed-radix index split.
// Request channel: start with linear_index and row_tag is taken at a rising
// edge where busy is low. busy stays low, so a new request may enter every
// cycle. Each request yields one result: digit_0..digit_4, nonzero_mask and
// out_row_tag appear for exactly one cycle with done high.
// From start to done a request passes every divider stage register and
// then the output register. Throughput: one request per cycle. Each
// dimension is a pipelined restoring divider resolving four quotient bits
// per stage, with the remainder taken as the digit and the quotient passed
// to the next dimension.
// Configuration: APB port, register i at byte address 4*i (dims_in_use,
// bound_0..bound_4). Write only while no request is in flight.
// Reset: all in-flight requests are dropped, dims_in_use and all bounds
// return to 1. The receiver cannot stall; results are never held back.
module mixed_radix_index_split
    import mris_pkg::*;
#(
    parameter int MAX_DIMS   = DEF_MAX_DIMS,
    parameter int INDEX_BITS = DEF_INDEX_BITS,
    parameter int BOUND_BITS = DEF_BOUND_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_BITS-1:0]    paddr,
    input  logic [DATA_BITS-1:0]    pwdata,
    output logic [DATA_BITS-1:0]    prdata,
    output logic                    pready,
    input  logic                    start,
    output logic                    busy,
    input  logic [INDEX_BITS-1:0]   linear_index,
    input  logic [TAG_BITS-1:0]     row_tag,
    output logic                    done,
    output logic [BOUND_BITS-1:0]   digit_0,
    output logic [BOUND_BITS-1:0]   digit_1,
    output logic [BOUND_BITS-1:0]   digit_2,
    output logic [BOUND_BITS-1:0]   digit_3,
    output logic [BOUND_BITS-1:0]   digit_4,
    output logic [FIELD_DIGITS-1:0] nonzero_mask,
    output logic [TAG_BITS-1:0]     out_row_tag
);

    localparam int SPD     = (INDEX_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int NSTAGES = MAX_DIMS * SPD;
    localparam int LATENCY = NSTAGES + 1;

    typedef logic [FIELD_DIGITS-1:0][BOUND_BITS-1:0] dig_arr_t;

    logic [COUNT_BITS-1:0] dims_in_use;
    dig_arr_t              bounds;

    logic                  st_v   [0:NSTAGES];
    logic [INDEX_BITS-1:0] st_num [0:NSTAGES];
    logic [BOUND_BITS-1:0] st_rem [0:NSTAGES];
    dig_arr_t              st_dig [0:NSTAGES];
    logic [TAG_BITS-1:0]   st_tag [0:NSTAGES];

    logic                  done_reg;
    dig_arr_t              dig_reg, dig_final;
    logic [TAG_BITS-1:0]   tag_reg;

    // Place finished remainder as digit, zero when dimension is unused
    function automatic dig_arr_t put_digit(dig_arr_t dig, int d,
                                           logic [BOUND_BITS-1:0] rem,
                                           logic [COUNT_BITS-1:0] cnt);
        dig_arr_t r;
        r = dig;
        r[d] = (COUNT_BITS'(d) < cnt) ? rem : '0;
        return r;
    endfunction

    mris_regs #(
        .BOUND_BITS (BOUND_BITS)
    ) u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .dims_in_use (dims_in_use),
        .bounds      (bounds)
    );

    // Pipeline never stalls
    assign busy = 1'b0;

    // Pipeline entry
    assign st_v[0]   = start;
    assign st_num[0] = linear_index;
    assign st_rem[0] = '0;
    assign st_dig[0] = '0;
    assign st_tag[0] = row_tag;

    // Divider stages, SPD per dimension
    for (genvar g = 0; g < NSTAGES; g++)
    begin : g_stage
        localparam int D = g / SPD;
        localparam int S = g % SPD;
        logic [BOUND_BITS-1:0] rem_in;
        dig_arr_t              dig_in;

        if (S == 0 && D > 0)
        begin : g_dim_start
            assign rem_in = '0;
            assign dig_in = put_digit(st_dig[g], D - 1, st_rem[g], dims_in_use);
        end
        else
        begin : g_dim_body
            assign rem_in = st_rem[g];
            assign dig_in = st_dig[g];
        end

        mris_div_stage #(
            .INDEX_BITS (INDEX_BITS),
            .BOUND_BITS (BOUND_BITS),
            .FIRST_STEP (S * STEP_BITS)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (st_v[g]),
            .in_num    (st_num[g]),
            .in_rem    (rem_in),
            .in_dig    (dig_in),
            .in_tag    (st_tag[g]),
            .divisor   (bounds[D]),
            .out_valid (st_v[g+1]),
            .out_num   (st_num[g+1]),
            .out_rem   (st_rem[g+1]),
            .out_dig   (st_dig[g+1]),
            .out_tag   (st_tag[g+1])
        );
    end

    assign dig_final = put_digit(st_dig[NSTAGES], MAX_DIMS - 1,
                                 st_rem[NSTAGES], dims_in_use);

    // Hold result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= st_v[NSTAGES];
        end
    end

    // Hold result payload
    always_ff @(posedge clk)
    begin
        dig_reg <= dig_final;
        tag_reg <= st_tag[NSTAGES];
    end

    assign done        = done_reg;
    assign digit_0     = dig_reg[0];
    assign digit_1     = dig_reg[1];
    assign digit_2     = dig_reg[2];
    assign digit_3     = dig_reg[3];
    assign digit_4     = dig_reg[4];
    assign out_row_tag = tag_reg;

    always_comb
    begin
        for (int i = 0; i < FIELD_DIGITS; i++)
        begin
            nonzero_mask[i] = (dig_reg[i] != '0);
        end
    end

`ifndef NO_ASSERTIONS
    // Every request yields a result after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("request did not produce a result on time");

    // Innermost digit stays below its nonzero bound
    a_digit0_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && dims_in_use != '0 && bounds[0] != '0) |-> (digit_0 < bounds[0]))
        else $error("innermost digit out of range");

    // A result without count gives no digits
    a_no_dims: assert property (@(posedge clk) disable iff (!rst_n)
        (done && dims_in_use == '0) |-> (nonzero_mask == '0))
        else $error("digit set with no dimensions in use");

    // Zero bound leaves innermost digit zero
    a_zero_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (done && bounds[0] == '0) |-> (digit_0 == '0))
        else $error("digit nonzero for zero bound");
`endif

endmodule
